@@ hdl/sgeb_pkg.sv @@
// shared constants and types of the sync gated event buffer
package sgeb_pkg;

	localparam int DEPTH   = 32;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int LIMIT_W = 6;
	localparam int CMP_W   = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);

	localparam logic [15:0] SYNC_TYPE   = 16'h0000;
	localparam logic [15:0] SYNC_REPORT = 16'h0000;

	// one stored event
	typedef struct packed {
		logic [31:0]        time_sec;
		logic [19:0]        time_usec;
		logic [15:0]        event_type;
		logic [15:0]        event_code;
		logic signed [31:0] event_value;
	} entry_t;

endpackage

@@ hdl/sync_gated_event_buffer_unit.sv @@
// top level of the sync gated event buffer: event store and release sequencer
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------------------
//  input     | start, busy         | time_sec, time_usec, event_type, event_code,
//            |                     | event_value
//  result    | out_valid (strobe)  | out_time_sec, out_time_usec, out_type,
//            |                     | out_code, out_value, is_last
//  config    | cfg_we              | cfg_wdata (queue_limit)
//
// a non-sync word is written to the store (or dropped when the store holds the
// limit) and busy stays low
// a sync report with n > 0 stored words keeps busy high while the n words are read
// through the single read port of the store and while the read register drains;
// the sync word itself follows as the last result
// a sync report into an empty store leaves busy low, the sync word comes out
// in the next cycle
// results leave at one word per cycle and the receiver cannot stall them
// reset clears the fill count, the sequencer and the limit (to 20); the store
// contents are not cleared, only entries written since the last release are read
module sync_gated_event_buffer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [31:0]                   time_sec,
	input  logic [19:0]                   time_usec,
	input  logic [15:0]                   event_type,
	input  logic [15:0]                   event_code,
	input  logic signed [31:0]            event_value,
	input  logic                          cfg_we,
	input  logic [sgeb_pkg::LIMIT_W-1:0]  cfg_wdata,
	output logic                          out_valid,
	output logic [31:0]                   out_time_sec,
	output logic [19:0]                   out_time_usec,
	output logic [15:0]                   out_type,
	output logic [15:0]                   out_code,
	output logic signed [31:0]            out_value,
	output logic                          is_last
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                        state_q;
	logic [sgeb_pkg::FILL_W-1:0]       fill_q;
	logic [sgeb_pkg::LIMIT_W-1:0]      limit_q;
	logic [sgeb_pkg::ADDR_W-1:0]       rd_ptr_q;
	logic [sgeb_pkg::ADDR_W-1:0]       last_q;
	sgeb_pkg::entry_t                  sync_q;

	// store and its registered read side
	sgeb_pkg::entry_t                  store_mem [sgeb_pkg::DEPTH];
	sgeb_pkg::entry_t                  rd_data_s1;
	logic                              rd_vld_s1;
	logic                              sync_vld_s1;

	sgeb_pkg::entry_t                  in_word;
	logic                              accept;
	logic                              is_sync;
	logic                              has_room;
	logic                              wr_en;
	logic                              rd_en;
	logic                              sync_rel;
	logic [sgeb_pkg::CMP_W-1:0]        limit_eff;
	sgeb_pkg::entry_t                  out_word;

	assign in_word = '{time_sec:    time_sec,
	                   time_usec:   time_usec,
	                   event_type:  event_type,
	                   event_code:  event_code,
	                   event_value: event_value};

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign is_sync = (event_type == sgeb_pkg::SYNC_TYPE) &&
	                 (event_code == sgeb_pkg::SYNC_REPORT);

	// limit above the store depth saturates at the depth
	always_comb begin
		if (sgeb_pkg::CMP_W'(limit_q) < sgeb_pkg::CMP_W'(sgeb_pkg::DEPTH)) begin
			limit_eff = sgeb_pkg::CMP_W'(limit_q);
		end else begin
			limit_eff = sgeb_pkg::CMP_W'(sgeb_pkg::DEPTH);
		end
	end

	assign has_room = sgeb_pkg::CMP_W'(fill_q) < limit_eff;
	assign wr_en    = accept && !is_sync && has_room;
	assign rd_en    = (state_q == ST_DRAIN);

	// sync word goes out after the flush step, or right away into an empty store
	assign sync_rel = (state_q == ST_FLUSH) || (accept && is_sync && (fill_q == '0));

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sgeb_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rd_ptr_q    <= '0;
			last_q      <= '0;
			rd_vld_s1   <= 1'b0;
			sync_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			sync_vld_s1 <= sync_rel;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_sync) begin
						fill_q <= '0;
						// empty store: the sync word goes out alone
						if (fill_q != '0) begin
							rd_ptr_q <= '0;
							last_q   <= sgeb_pkg::ADDR_W'(fill_q - 1'b1);
							state_q  <= ST_DRAIN;
						end
					end else if (wr_en) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					if (rd_ptr_q == last_q) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// last stored word is on the outputs now, sync word next
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sync word is held until it is released
	always_ff @(posedge clk) begin
		if (accept && is_sync) begin
			sync_q <= in_word;
		end
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[fill_q[sgeb_pkg::ADDR_W-1:0]] <= in_word;
		end
		if (rd_en) begin
			rd_data_s1 <= store_mem[rd_ptr_q];
		end
	end

	// result mux: stored words first, then the sync word
	assign out_word      = rd_vld_s1 ? rd_data_s1 : sync_q;
	assign out_valid     = rd_vld_s1 || sync_vld_s1;
	assign is_last       = sync_vld_s1;
	assign out_time_sec  = out_word.time_sec;
	assign out_time_usec = out_word.time_usec;
	assign out_type      = out_word.event_type;
	assign out_code      = out_word.event_code;
	assign out_value     = out_word.event_value;

	// stored read and sync release never collide
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_vld_s1 && sync_vld_s1))
		else $error("stored word and sync word released together");

	// fill count stays within the store
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sgeb_pkg::CMP_W'(fill_q) <= sgeb_pkg::CMP_W'(sgeb_pkg::DEPTH))
		else $error("fill count beyond store depth");

	// a sync report into an empty store is released in the next cycle as last
	a_sync_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_sync && fill_q == '0) |=> (out_valid && is_last))
		else $error("sync word not released after empty store");

	// a drain always ends with the sync word in the cycle after the flush step
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (rd_vld_s1 == 1'b0 && sync_vld_s1 && !busy))
		else $error("release run not closed by sync word");

	// no write into the store while it is being read out
	a_no_write_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("store written during release");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench of the sync gated event buffer: directed corners, then random frames
module tb_top;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 11;
	// this leaves a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT   = 200000;
	// the directed tests send 28 words ahead of these
	localparam int RANDOM_WORDS  = 392;
	// words in the last stretch of the run go out back to back
	localparam int QUIET_WORDS   = 80;
	// a stored or dropped word leaves busy low; margin after the last due result
	localparam int SETTLE_CYCLES = 4;
	// a full release run is DEPTH + 1 words plus the read register drain
	localparam int END_CYCLES    = sgeb_pkg::DEPTH + 8;

	// one expected result: the released word and its end-of-run mark
	typedef struct packed {
		sgeb_pkg::entry_t ev;
		logic             last;
	} release_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	sgeb_pkg::entry_t             drive_word;
	logic                         cfg_we;
	logic [sgeb_pkg::LIMIT_W-1:0] cfg_wdata;
	logic                         out_valid;
	logic [31:0]                  out_time_sec;
	logic [19:0]                  out_time_usec;
	logic [15:0]                  out_type;
	logic [15:0]                  out_code;
	logic signed [31:0]           out_value;
	logic                         is_last;

	// predictor state: the limit register, the held words and their count
	logic [sgeb_pkg::LIMIT_W-1:0] model_limit;
	sgeb_pkg::entry_t             held_word [sgeb_pkg::DEPTH];
	int                           held_cnt;
	release_t                     release_q [$];
	release_t                     due;

	// bookkeeping for the summary
	int  counted_words;
	int  stored_cnt;
	int  dropped_cnt;
	int  sync_cnt;
	int  checked_cnt;
	int  fail_cnt;
	int  cycle_cnt;
	bit  quiet_tail;

	sync_gated_event_buffer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.time_sec      (drive_word.time_sec),
		.time_usec     (drive_word.time_usec),
		.event_type    (drive_word.event_type),
		.event_code    (drive_word.event_code),
		.event_value   (drive_word.event_value),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_time_sec  (out_time_sec),
		.out_time_usec (out_time_usec),
		.out_type      (out_type),
		.out_code      (out_code),
		.out_value     (out_value),
		.is_last       (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycle_cnt, release_q.size());
		$display("Some tests failed");
		$finish;
	end

	// predictor: takes one accepted word, queues the results it releases
	// returns 0 when the word is dropped at the limit
	function automatic bit predict_word(input sgeb_pkg::entry_t w);
		int       cap;
		release_t r;
		cap = (model_limit < sgeb_pkg::DEPTH) ? int'(model_limit) : sgeb_pkg::DEPTH;
		if (w.event_type == sgeb_pkg::SYNC_TYPE && w.event_code == sgeb_pkg::SYNC_REPORT) begin
			// sync report: every held word in arrival order, then the sync itself
			for (int i = 0; i < held_cnt; i++) begin
				r.ev   = held_word[i];
				r.last = 1'b0;
				release_q.push_back(r);
			end
			r.ev   = w;
			r.last = 1'b1;
			release_q.push_back(r);
			held_cnt = 0;
			sync_cnt++;
			return 1'b1;
		end
		// any other word, type 0 with a nonzero code included, is held if room remains
		if (held_cnt >= cap) begin
			dropped_cnt++;
			return 1'b0;
		end
		held_word[held_cnt] = w;
		held_cnt++;
		stored_cnt++;
		return 1'b1;
	endfunction

	function automatic sgeb_pkg::entry_t mk_word(input logic [31:0] sec,
			input logic [19:0] usec, input logic [15:0] typ, input logic [15:0] code,
			input logic signed [31:0] val);
		sgeb_pkg::entry_t w;
		w.time_sec    = sec;
		w.time_usec   = usec;
		w.event_type  = typ;
		w.event_code  = code;
		w.event_value = val;
		return w;
	endfunction

	// random non-sync word; now and then the sync class with a nonzero code
	// and microseconds beyond the legal range
	function automatic sgeb_pkg::entry_t rand_event();
		sgeb_pkg::entry_t w;
		w.time_sec  = $urandom;
		w.time_usec = ($urandom_range(0, 7) == 0) ? 20'($urandom)
			: 20'($urandom_range(0, 999999));
		case ($urandom_range(0, 5))
			0: begin
				w.event_type = sgeb_pkg::SYNC_TYPE;
				w.event_code = 16'($urandom_range(1, 65535));
			end
			1: begin
				w.event_type = 16'hFFFF;
				w.event_code = 16'($urandom);
			end
			default: begin
				w.event_type = 16'($urandom_range(1, 65535));
				w.event_code = 16'($urandom);
			end
		endcase
		w.event_value = $urandom;
		return w;
	endfunction

	// sync report with random timestamp and value
	function automatic sgeb_pkg::entry_t rand_sync();
		sgeb_pkg::entry_t w;
		w.time_sec    = $urandom;
		w.time_usec   = ($urandom_range(0, 7) == 0) ? 20'($urandom)
			: 20'($urandom_range(0, 999999));
		w.event_type  = sgeb_pkg::SYNC_TYPE;
		w.event_code  = sgeb_pkg::SYNC_REPORT;
		w.event_value = $urandom;
		return w;
	endfunction

	// present one word from a falling edge and hold it until busy is low at a rising edge
	// start stays high afterwards so back-to-back words need no extra edge
	task automatic send_word(input sgeb_pkg::entry_t w);
		@(negedge clk);
		drive_word = w;
		start      = 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		void'(predict_word(w));
		counted_words++;
	endtask

	// random run of idle cycles before the next word, none in the quiet tail
	task automatic idle_gap();
		int n;
		if (!quiet_tail && $urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 6);
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// stop sending, let every due result come out, then wait SETTLE_CYCLES more
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (release_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// the limit register is only written with the block idle
	task automatic write_limit(input logic [sgeb_pkg::LIMIT_W-1:0] lim);
		settle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = lim;
		@(posedge clk);
		model_limit = lim;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			fail_cnt++;
		end
	endtask

	// result checker: every strobed word is compared with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (release_q.size() == 0) begin
				$error("result word with nothing due: type %h code %h value %h",
					out_type, out_code, out_value);
				fail_cnt++;
			end else begin
				due = release_q.pop_front();
				check_field("out_time_sec", due.ev.time_sec, out_time_sec);
				check_field("out_time_usec", 32'(due.ev.time_usec), 32'(out_time_usec));
				check_field("out_type", 32'(due.ev.event_type), 32'(out_type));
				check_field("out_code", 32'(due.ev.event_code), 32'(out_code));
				check_field("out_value", due.ev.event_value, out_value);
				check_field("is_last", 32'(due.last), 32'(is_last));
				checked_cnt++;
			end
		end
	end

	// limit left at its reset value of 20: the first words carry the field extremes,
	// the sync class with nonzero codes and microseconds above 999999; the
	// twenty-first word finds the store full and is dropped
	task automatic test_reset_limit();
		send_word(mk_word(32'h0000_0000, 20'd0, 16'h0001, 16'h0000, 32'sh8000_0000));
		idle_gap();
		send_word(mk_word(32'hFFFF_FFFF, 20'd999999, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF));
		send_word(mk_word(32'h8000_0001, 20'hFFFFF, sgeb_pkg::SYNC_TYPE, 16'h0001, -32'sd1));
		send_word(mk_word(32'h5555_5555, 20'hAAAAA, sgeb_pkg::SYNC_TYPE, 16'hFFFF,
			32'sh0000_0000));
		repeat (int'(sgeb_pkg::LIMIT_RESET) - 3) begin
			idle_gap();
			send_word(rand_event());
		end
		// release with extreme sync fields
		send_word(mk_word(32'hFFFF_FFFF, 20'hFFFFF, sgeb_pkg::SYNC_TYPE, sgeb_pkg::SYNC_REPORT,
			32'sh8000_0000));
	endtask

	// limit zero: every word is dropped, the sync releases only itself
	task automatic test_limit_zero();
		write_limit(6'd0);
		send_word(rand_event());
		send_word(mk_word(32'h0000_0000, 20'd0, sgeb_pkg::SYNC_TYPE, sgeb_pkg::SYNC_REPORT,
			32'sh7FFF_FFFF));
	endtask

	// limit lowered below the fill: held words stay and still come out at the sync
	task automatic test_limit_lowered();
		write_limit(6'd2);
		send_word(rand_event());
		send_word(rand_event());
		write_limit(6'd1);
		send_word(rand_event());
		send_word(rand_sync());
	endtask

	// random phases, each with its own limit: the top of the range (above the store
	// depth), the exact depth, zero and one first, then mostly small limits; frames
	// of random length end in a sync, a few are left open and spill into the next
	task automatic test_random_traffic();
		int                           goal;
		int                           phase;
		int                           frames;
		int                           burst;
		int                           cap;
		logic [sgeb_pkg::LIMIT_W-1:0] lim;
		goal  = counted_words + RANDOM_WORDS;
		phase = 0;
		while (counted_words < goal) begin
			case (phase)
				0: lim = 6'd63;
				1: lim = 6'(sgeb_pkg::DEPTH);
				2: lim = 6'd0;
				3: lim = 6'd1;
				default: lim = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(1, 12));
			endcase
			write_limit(lim);
			cap        = (lim < sgeb_pkg::DEPTH) ? int'(lim) : sgeb_pkg::DEPTH;
			quiet_tail = (counted_words + QUIET_WORDS >= goal);
			frames     = $urandom_range(1, 4);
			repeat (frames) begin
				// up to three words past the limit so drops show up in some frames
				burst = $urandom_range(0, cap + 3);
				repeat (burst) begin
					idle_gap();
					send_word(rand_event());
				end
				if ($urandom_range(0, 7) != 0) begin
					idle_gap();
					send_word(rand_sync());
				end
			end
			phase++;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		drive_word    = '0;
		model_limit   = sgeb_pkg::LIMIT_RESET;
		held_cnt      = 0;
		counted_words = 0;
		stored_cnt    = 0;
		dropped_cnt   = 0;
		sync_cnt      = 0;
		checked_cnt   = 0;
		fail_cnt      = 0;
		quiet_tail    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_limit();
		test_limit_zero();
		test_limit_lowered();
		test_random_traffic();

		// drain: all due results, then a full release time for any stray word
		@(negedge clk);
		start = 1'b0;
		while (release_q.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		$display("%0d words held, %0d dropped at the limit, %0d syncs released",
			stored_cnt, dropped_cnt, sync_cnt);
		$display("%0d result words checked, limits from 0 up to 63", checked_cnt);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sync_gated_event_buffer_unit.f @@
hdl/sgeb_pkg.sv
hdl/sync_gated_event_buffer_unit.sv
tb/sv/tb_top.sv
